// File: rtl/core/bitset_set_bit_enumerator_unit_macros.svh
// Assertion macros for the bitset set-bit enumerator.
// Depends on nothing; the asserting file must provide clk and rst_n.
`ifndef BITSET_SET_BIT_ENUMERATOR_UNIT_MACROS_SVH
`define BITSET_SET_BIT_ENUMERATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define BSENUM_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BSENUM_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BSENUM_CHECK(label, ante, cons, msg)
`define BSENUM_CHECK_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/core/bsenum_pkg.sv
// Shared constants, request codes and types of the bitset set-bit enumerator.
// Depends on nothing.
package bsenum_pkg;

    localparam int WORD_BITS      = 32;
    localparam int WORD_LOG       = 5;
    localparam int DEF_NUM_WORDS  = 8;
    localparam int DEF_MAX_LIST   = 64;
    // Positions run up to 511; one more bit holds the word-rounded size.
    localparam int POS_W          = 10;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_FWD  = 2'd1;
    localparam logic [1:0] REQ_REV  = 2'd2;

    typedef struct packed {
        logic                hit;
        logic [WORD_LOG-1:0] ofs;
    } pick_t;

endpackage

// File: rtl/core/bsenum_pick.sv
// Picks the next set bit of one word, lowest or highest, and clears it.
// Depends on bsenum_pkg.
module bsenum_pick (
    input  logic [bsenum_pkg::WORD_BITS-1:0] word,
    input  logic                             rev,
    output bsenum_pkg::pick_t                pick,
    output logic [bsenum_pkg::WORD_BITS-1:0] rest
);
    import bsenum_pkg::*;

    always_comb
    begin
        pick = '0;
        // The last match written wins, so the scan order sets the priority.
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (rev)
            begin
                if (word[i])
                begin
                    pick.ofs = WORD_LOG'(i);
                end
            end
            else
            begin
                if (word[WORD_BITS-1-i])
                begin
                    pick.ofs = WORD_LOG'(WORD_BITS-1-i);
                end
            end
        end
        pick.hit = |word;
        rest = word & ~(WORD_BITS'(1) << pick.ofs);
    end

endmodule

// File: rtl/core/bitset_set_bit_enumerator_unit.sv
// Bitset set-bit enumerator: a load gives no result; a list request visits the stored
// words in scan order, takes each index found from the single shared bit picker and ends
// with one final result. Results leave through an output register, so a stalled last
// result does not hold back the next request. Reset clears the stored words and sets
// set_bits to 256.
`include "bitset_set_bit_enumerator_unit_macros.svh"

// Top level of the bitset set-bit enumerator.
// Depends on bsenum_pkg, bsenum_pick and the assertion macros header.
module bitset_set_bit_enumerator_unit #(
    parameter int NUM_WORDS = bsenum_pkg::DEF_NUM_WORDS,
    parameter int MAX_LIST  = bsenum_pkg::DEF_MAX_LIST
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [8:0]                       cfg_wr_data,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [1:0]                       req_type,
    input  logic [2:0]                       word_index,
    input  logic [bsenum_pkg::WORD_BITS-1:0] word_data,
    input  logic [8:0]                       start_pos,
    input  logic [6:0]                       max_count,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [7:0]                       bit_index,
    output logic                             found,
    output logic                             last,
    output logic [6:0]                       hit_count,
    output logic [8:0]                       next_pos
);
    import bsenum_pkg::*;

    localparam int WIDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CAP    = NUM_WORDS * WORD_BITS;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FINAL = 3'b100
    } state_t;

    // Mask of the n lowest bits of a word; n of a whole word or more gives all ones.
    function automatic logic [WORD_BITS-1:0] low_mask(input logic [WORD_LOG:0] n);
        logic [WORD_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

    // Configuration register and the stored bitset.
    logic [8:0]           set_bits_reg;
    logic [WORD_BITS-1:0] bit_store_reg [NUM_WORDS];

    // Sequencer state.
    state_t               state_reg,      state_next;
    logic [WIDX_W-1:0]    w_reg,          w_next;
    logic [WIDX_W-1:0]    last_w_reg,     last_w_next;
    logic [WORD_BITS-1:0] work_reg,       work_next;
    logic                 dir_reg,        dir_next;
    logic [6:0]           maxc_reg,       maxc_next;
    logic [6:0]           count_reg,      count_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [POS_W-1:0]     pend_pos_reg,   pend_pos_next;
    logic [POS_W-1:0]     nxt_reg,        nxt_next;

    // Output register.
    logic                 out_valid_reg,  out_valid_next;
    logic [7:0]           out_index_reg,  out_index_next;
    logic                 out_found_reg,  out_found_next;
    logic                 out_last_reg,   out_last_next;
    logic [6:0]           out_count_reg,  out_count_next;
    logic [8:0]           out_pos_reg,    out_pos_next;
    logic                 out_load;
    logic                 out_free;

    logic                 accept;
    logic                 load_en;
    logic [WORD_BITS-1:0] load_word;
    logic [POS_W-1:0]     load_base;
    logic [POS_W-1:0]     load_rem;

    logic [POS_W-1:0]     size;
    logic [POS_W-1:0]     size_round;
    logic [POS_W-1:0]     start_ext;
    logic [POS_W-1:0]     top_pos;
    logic [6:0]           maxc_in;
    logic                 in_rev;

    // Masked word fetch, shared by the request start and the word advance.
    logic [WIDX_W-1:0]    w_sel;
    logic                 first_sel;
    logic                 rev_sel;
    logic [WORD_LOG-1:0]  lo_sel;
    logic [POS_W-1:0]     sel_base;
    logic [POS_W-1:0]     sel_rem;
    logic [WORD_BITS-1:0] sel_mask;
    logic [WORD_BITS-1:0] sel_word;

    logic [WIDX_W-1:0]    w_adv;
    logic [POS_W-1:0]     cur_base;
    logic [POS_W-1:0]     hit_pos;
    logic [6:0]           count_inc;
    logic                 scan_done;
    pick_t                pick;
    logic [WORD_BITS-1:0] pick_rest;

    // The size in use is the register saturated to the store's capacity.
    always_comb
    begin
        if (int'(set_bits_reg) > CAP)
        begin
            size = POS_W'(CAP);
        end
        else
        begin
            size = POS_W'(set_bits_reg);
        end
    end

    assign size_round = (size + POS_W'(WORD_BITS - 1)) & ~POS_W'(WORD_BITS - 1);
    assign start_ext  = POS_W'(start_pos);
    assign top_pos    = size - POS_W'(1) - start_ext;
    assign in_rev     = (req_type == REQ_REV);

    always_comb
    begin
        if (max_count == 7'd0)
        begin
            maxc_in = 7'd1;
        end
        else if (int'(max_count) > MAX_LIST)
        begin
            maxc_in = 7'(MAX_LIST);
        end
        else
        begin
            maxc_in = max_count;
        end
    end

    // A request transfer is taken only while the sequencer is idle.
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !out_valid_reg || !rsp_stall;

    // Loads clear bits at or above the size as they are written.
    assign load_en   = accept && (req_type == REQ_LOAD) && (int'(word_index) < NUM_WORDS);
    assign load_base = POS_W'(word_index) << WORD_LOG;
    assign load_rem  = size - load_base;

    always_comb
    begin
        load_word = word_data;
        if (load_base >= size)
        begin
            load_word = '0;
        end
        else if (load_rem < POS_W'(WORD_BITS))
        begin
            load_word = word_data & low_mask(load_rem[WORD_LOG:0]);
        end
    end

    // Word fetch: on a request it reads the start word, later the next word in scan order.
    // A forward scan drops bits below the start and at or above the size; a reverse scan
    // drops bits above its start, which also hides stale bits above the size.
    assign w_adv = dir_reg ? (w_reg - WIDX_W'(1)) : (w_reg + WIDX_W'(1));

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            first_sel = 1'b1;
            rev_sel   = in_rev;
            if (in_rev)
            begin
                w_sel  = WIDX_W'(top_pos >> WORD_LOG);
                lo_sel = top_pos[WORD_LOG-1:0];
            end
            else
            begin
                w_sel  = WIDX_W'(start_ext >> WORD_LOG);
                lo_sel = start_ext[WORD_LOG-1:0];
            end
        end
        else
        begin
            first_sel = 1'b0;
            rev_sel   = dir_reg;
            w_sel     = w_adv;
            lo_sel    = '0;
        end
    end

    assign sel_base = POS_W'(w_sel) << WORD_LOG;
    assign sel_rem  = size - sel_base;

    always_comb
    begin
        sel_mask = '1;
        if (!rev_sel)
        begin
            if (first_sel)
            begin
                sel_mask = sel_mask & ~low_mask({1'b0, lo_sel});
            end
            if (sel_rem < POS_W'(WORD_BITS))
            begin
                sel_mask = sel_mask & low_mask(sel_rem[WORD_LOG:0]);
            end
        end
        else if (first_sel)
        begin
            sel_mask = low_mask((WORD_LOG + 1)'({1'b0, lo_sel}) + (WORD_LOG + 1)'(1));
        end
    end

    assign sel_word = bit_store_reg[w_sel] & sel_mask;

    // The shared picker finds one set bit of work_reg per cycle unless the output stalls.
    bsenum_pick u_pick (
        .word (work_reg),
        .rev  (dir_reg),
        .pick (pick),
        .rest (pick_rest)
    );

    assign cur_base  = POS_W'(w_reg) << WORD_LOG;
    assign hit_pos   = cur_base + POS_W'(pick.ofs);
    assign count_inc = count_reg + 7'd1;
    assign scan_done = dir_reg ? (w_reg == '0) : (w_reg == last_w_reg);

    // Sequencer. A found index is held as pending until the next one is found or the scan
    // ends, so the final result can carry the count and the resume position.
    always_comb
    begin
        state_next      = state_reg;
        w_next          = w_reg;
        last_w_next     = last_w_reg;
        work_next       = work_reg;
        dir_next        = dir_reg;
        maxc_next       = maxc_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        nxt_next        = nxt_reg;
        out_load        = 1'b0;
        out_index_next  = out_index_reg;
        out_found_next  = out_found_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        out_pos_next    = out_pos_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_FWD || req_type == REQ_REV))
                begin
                    dir_next        = in_rev;
                    maxc_next       = maxc_in;
                    count_next      = '0;
                    pend_valid_next = 1'b0;
                    pend_pos_next   = '0;
                    if (start_ext >= size)
                    begin
                        // A start at or past the end reports itself as the resume position.
                        nxt_next   = start_ext;
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        w_next      = w_sel;
                        last_w_next = WIDX_W'((size - POS_W'(1)) >> WORD_LOG);
                        work_next   = sel_word;
                        state_next  = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (pick.hit)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load       = 1'b1;
                            out_index_next = pend_pos_reg[7:0];
                            out_found_next = 1'b1;
                            out_last_next  = 1'b0;
                            out_count_next = '0;
                            out_pos_next   = '0;
                        end
                        pend_valid_next = 1'b1;
                        pend_pos_next   = hit_pos;
                        count_next      = count_inc;
                        work_next       = pick_rest;
                        if (count_inc == maxc_reg)
                        begin
                            nxt_next   = dir_reg ? (size - hit_pos) : (hit_pos + POS_W'(1));
                            state_next = ST_FINAL;
                        end
                    end
                end
                else if (scan_done)
                begin
                    nxt_next   = dir_reg ? size : size_round;
                    state_next = ST_FINAL;
                end
                else
                begin
                    w_next    = w_adv;
                    work_next = sel_word;
                end
            end

            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_index_next  = pend_valid_reg ? pend_pos_reg[7:0] : 8'd0;
                    out_found_next  = pend_valid_reg;
                    out_last_next   = 1'b1;
                    out_count_next  = count_reg;
                    out_pos_next    = nxt_reg[8:0];
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            set_bits_reg   <= 9'd256;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                set_bits_reg <= cfg_wr_data;
            end
        end
    end

    // The stored bitset reads as all zeros after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                bit_store_reg[i] <= '0;
            end
        end
        else if (load_en)
        begin
            bit_store_reg[WIDX_W'(word_index)] <= load_word;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        w_reg         <= w_next;
        last_w_reg    <= last_w_next;
        work_reg      <= work_next;
        dir_reg       <= dir_next;
        maxc_reg      <= maxc_next;
        pend_pos_reg  <= pend_pos_next;
        nxt_reg       <= nxt_next;
        out_index_reg <= out_index_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
        out_count_reg <= out_count_next;
        out_pos_reg   <= out_pos_next;
    end

    assign rsp_valid = out_valid_reg;
    assign bit_index = out_index_reg;
    assign found     = out_found_reg;
    assign last      = out_last_reg;
    assign hit_count = out_count_reg;
    assign next_pos  = out_pos_reg;

    // The running count never passes the saturated list limit.
    `BSENUM_CHECK(a_count_bounded, state_reg != ST_IDLE, count_reg <= maxc_reg, "count above limit")
    // A pending index is always already counted.
    `BSENUM_CHECK(a_pend_counted, pend_valid_reg, count_reg != 7'd0, "pending hit not counted")
    // Only the final result of a request can lack a found index.
    `BSENUM_CHECK(a_inner_found, rsp_valid && !last, found, "inner result without a hit")
    // Once the final result is handed to the output register, the sequencer is idle.
    `BSENUM_CHECK_NEXT(a_final_idle, state_reg == ST_FINAL && out_free, state_reg == ST_IDLE, "final result did not end request")

endmodule
